// ===== rtl/core/swis_pkg.sv =====
`timescale 1ns / 1ps

package swis_pkg;

    localparam logic [7:0]  GAP_CHAR  = 8'd46;
    localparam logic [12:0] WL_RESET  = 13'd20;

    typedef enum logic [1:0] {
        CLS_DOUBLE_GAP = 2'd0,
        CLS_ONE_GAP    = 2'd1,
        CLS_COMMON     = 2'd2,
        CLS_IDENTICAL  = 2'd3
    } cls_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPD,
        S_CHK,
        S_WDIV,
        S_WMUL,
        S_WACC,
        S_FIN,
        S_FDIV_AVG,
        S_LDMSQ,
        S_FDIV_MSQ,
        S_FMUL,
        S_FSUB,
        S_SQRT,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic cfg_write;
        logic accept;
        logic update;
        logic div_load_win;
        logic pid_zero;
        logic div_load_sum;
        logic div_load_sq;
        logic div_step;
        logic mul_pid;
        logic wacc;
        logic save_avg;
        logic save_msq;
        logic mul_avg;
        logic sqrt_load;
        logic sqrt_step;
        logic res_zero;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic w_zero;
        logic win_ok;
        logic common_zero;
        logic iter_last;
        logic is_last;
        logic wc_zero;
        logic out_free;
    } status_t;

    function automatic cls_t classify(input logic [7:0] a, input logic [7:0] b);
        cls_t c;
        if (a == GAP_CHAR || b == GAP_CHAR)
            c = (a == b) ? CLS_DOUBLE_GAP : CLS_ONE_GAP;
        else
            c = (a == b) ? CLS_IDENTICAL : CLS_COMMON;
        return c;
    endfunction

endpackage

// ===== rtl/core/swis_ram.sv =====
`timescale 1ns / 1ps

module swis_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
        if (re)
            rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/swis_ctrl.sv =====
`timescale 1ns / 1ps

module swis_ctrl
    import swis_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  logic    cfg_valid,
    output logic    cfg_ready,
    input  status_t st,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!cfg_valid && in_valid)
                    state_next = st.w_zero ? S_FIN : S_UPD;
            end
            S_UPD:      state_next = S_CHK;
            S_CHK:
            begin
                if (!st.win_ok)
                    state_next = S_FIN;
                else if (st.common_zero)
                    state_next = S_WMUL;
                else
                    state_next = S_WDIV;
            end
            S_WDIV:     if (st.iter_last) state_next = S_WMUL;
            S_WMUL:     state_next = S_WACC;
            S_WACC:     state_next = S_FIN;
            S_FIN:
            begin
                if (!st.is_last)
                    state_next = S_IDLE;
                else if (st.wc_zero)
                    state_next = S_EMIT;
                else
                    state_next = S_FDIV_AVG;
            end
            S_FDIV_AVG: if (st.iter_last) state_next = S_LDMSQ;
            S_LDMSQ:    state_next = S_FDIV_MSQ;
            S_FDIV_MSQ: if (st.iter_last) state_next = S_FMUL;
            S_FMUL:     state_next = S_FSUB;
            S_FSUB:     state_next = S_SQRT;
            S_SQRT:     if (st.iter_last) state_next = S_EMIT;
            S_EMIT:     if (st.out_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        cfg_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                cfg_ready      = 1'b1;
                in_ready       = !cfg_valid;
                cmd.cfg_write  = cfg_valid;
                cmd.accept     = !cfg_valid && in_valid;
            end
            S_UPD:      cmd.update = 1'b1;
            S_CHK:
            begin
                cmd.pid_zero     = st.win_ok && st.common_zero;
                cmd.div_load_win = st.win_ok && !st.common_zero;
            end
            S_WDIV:     cmd.div_step = 1'b1;
            S_WMUL:     cmd.mul_pid = 1'b1;
            S_WACC:     cmd.wacc = 1'b1;
            S_FIN:
            begin
                cmd.res_zero     = st.is_last && st.wc_zero;
                cmd.div_load_sum = st.is_last && !st.wc_zero;
            end
            S_FDIV_AVG: cmd.div_step = 1'b1;
            S_LDMSQ:
            begin
                cmd.save_avg    = 1'b1;
                cmd.div_load_sq = 1'b1;
            end
            S_FDIV_MSQ: cmd.div_step = 1'b1;
            S_FMUL:
            begin
                cmd.save_msq = 1'b1;
                cmd.mul_avg  = 1'b1;
            end
            S_FSUB:     cmd.sqrt_load = 1'b1;
            S_SQRT:     cmd.sqrt_step = 1'b1;
            S_EMIT:     cmd.emit = st.out_free;
            default:    cmd = '0;
        endcase
    end

endmodule

// ===== rtl/core/swis_dp.sv =====
`timescale 1ns / 1ps

module swis_dp
    import swis_pkg::*;
#(
    parameter int MAX_LENGTH = 4096,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cmd_t                          cmd,
    output status_t                       st,
    input  logic [12:0]                   window_size,
    input  logic [7:0]                    residue_a,
    input  logic [7:0]                    residue_b,
    input  logic                          last,
    output logic                          ram_we,
    output logic [$clog2(MAX_LENGTH)-1:0] ram_waddr,
    output logic [1:0]                    ram_wdata,
    output logic                          ram_re,
    output logic [$clog2(MAX_LENGTH)-1:0] ram_raddr,
    input  logic [1:0]                    ram_rdata,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [16:0]                   avg_identity,
    output logic [16:0]                   identity_stdev,
    output logic [12:0]                   window_count
);

    localparam int AW = $clog2(MAX_LENGTH);
    localparam int CW = $clog2(MAX_LENGTH + 1);
    localparam int PW = FRAC_BITS + 1;
    localparam int SW = PW + CW;
    localparam int IW = $clog2(PW + 1);

    logic [12:0]   wl_reg;
    logic          last_reg;
    cls_t          cls_reg;
    logic [AW-1:0] pos_reg;
    logic [CW-1:0] fill_reg, common_reg, ident_reg, dg_reg, wc_reg;
    logic [SW-1:0] sum_reg, sq_reg;

    logic [CW-1:0] drem_reg, ddiv_reg;
    logic [PW-1:0] dlow_reg;
    logic [IW-1:0] iter_reg;
    logic [2*PW-1:0] prod_reg;
    logic [PW-1:0] avg_reg, msq_reg;
    logic [2*PW-1:0] sop_reg;
    logic [PW-1:0] sres_reg;
    logic [PW+1:0] srem_reg;

    logic          out_valid_reg;
    logic [16:0]   out_avg_reg, out_sd_reg;
    logic [12:0]   out_wc_reg;

    logic [CW-1:0] w_eff;
    logic          full;
    cls_t          old_cls;
    logic [CW-1:0] pos_inc;
    logic [CW:0]   dtrial;
    logic          dge;
    logic [PW+3:0] sfull, strial;
    logic          sge;
    logic [PW-1:0] sqm, diff;
    logic [SW-1:0] win_dividend;
    logic          clear;

    function automatic logic [CW-1:0] bump(input logic [CW-1:0] v, input logic add,
                                           input logic sub);
        logic [CW-1:0] r;
        r = v;
        if (add && !sub) r = v + CW'(1);
        if (sub && !add) r = v - CW'(1);
        return r;
    endfunction

    assign w_eff   = (32'(wl_reg) > MAX_LENGTH) ? CW'(MAX_LENGTH) : CW'(wl_reg);
    assign full    = fill_reg >= w_eff;
    assign old_cls = cls_t'(ram_rdata);
    assign pos_inc = CW'(pos_reg) + CW'(1);
    assign dtrial  = {drem_reg, dlow_reg[PW-1]};
    assign dge     = dtrial >= {1'b0, ddiv_reg};
    assign sfull   = {srem_reg, sop_reg[2*PW-1 -: 2]};
    assign strial  = (PW+4)'({sres_reg, 2'b01});
    assign sge     = sfull >= strial;
    assign sqm     = PW'(prod_reg >> FRAC_BITS);
    assign diff    = (msq_reg > sqm) ? (msq_reg - sqm) : '0;
    assign win_dividend = SW'(ident_reg) << FRAC_BITS;
    assign clear   = cmd.cfg_write || cmd.emit;

    assign ram_re    = cmd.accept;
    assign ram_raddr = pos_reg;
    assign ram_we    = cmd.update;
    assign ram_waddr = pos_reg;
    assign ram_wdata = cls_reg;

    assign st.w_zero      = (w_eff == '0);
    assign st.win_ok      = (fill_reg == w_eff) && (dg_reg != w_eff)
                            && (32'(wc_reg) < MAX_LENGTH);
    assign st.common_zero = (common_reg == '0);
    assign st.iter_last   = (iter_reg == IW'(1));
    assign st.is_last     = last_reg;
    assign st.wc_zero     = (wc_reg == '0);
    assign st.out_free    = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg        <= WL_RESET;
            pos_reg       <= '0;
            fill_reg      <= '0;
            common_reg    <= '0;
            ident_reg     <= '0;
            dg_reg        <= '0;
            wc_reg        <= '0;
            sum_reg       <= '0;
            sq_reg        <= '0;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cfg_write)
                wl_reg <= window_size;

            if (clear)
            begin
                pos_reg    <= '0;
                fill_reg   <= '0;
                common_reg <= '0;
                ident_reg  <= '0;
                dg_reg     <= '0;
                wc_reg     <= '0;
                sum_reg    <= '0;
                sq_reg     <= '0;
            end
            else if (cmd.update)
            begin
                common_reg <= bump(common_reg, cls_reg[1], full && old_cls[1]);
                ident_reg  <= bump(ident_reg, cls_reg == CLS_IDENTICAL,
                                   full && old_cls == CLS_IDENTICAL);
                dg_reg     <= bump(dg_reg, cls_reg == CLS_DOUBLE_GAP,
                                   full && old_cls == CLS_DOUBLE_GAP);
                pos_reg    <= (pos_inc == w_eff) ? '0 : AW'(pos_inc);
                if (!full)
                    fill_reg <= fill_reg + CW'(1);
            end
            else if (cmd.wacc)
            begin
                sum_reg <= sum_reg + SW'(dlow_reg);
                sq_reg  <= sq_reg + SW'(prod_reg >> FRAC_BITS);
                wc_reg  <= wc_reg + CW'(1);
            end

            if (cmd.div_load_win || cmd.div_load_sum || cmd.div_load_sq || cmd.sqrt_load)
                iter_reg <= IW'(PW);
            else if (cmd.div_step || cmd.sqrt_step)
                iter_reg <= iter_reg - IW'(1);

            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cls_reg  <= classify(residue_a, residue_b);
            last_reg <= last;
        end

        if (cmd.div_load_win)
        begin
            drem_reg <= win_dividend[SW-1:PW];
            dlow_reg <= win_dividend[PW-1:0];
            ddiv_reg <= common_reg;
        end
        else if (cmd.div_load_sum)
        begin
            drem_reg <= sum_reg[SW-1:PW];
            dlow_reg <= sum_reg[PW-1:0];
            ddiv_reg <= wc_reg;
        end
        else if (cmd.div_load_sq)
        begin
            drem_reg <= sq_reg[SW-1:PW];
            dlow_reg <= sq_reg[PW-1:0];
            ddiv_reg <= wc_reg;
        end
        else if (cmd.pid_zero)
            dlow_reg <= '0;
        else if (cmd.div_step)
        begin
            drem_reg <= dge ? CW'(dtrial - {1'b0, ddiv_reg}) : dtrial[CW-1:0];
            dlow_reg <= {dlow_reg[PW-2:0], dge};
        end

        if (cmd.mul_pid)
            prod_reg <= (2*PW)'(dlow_reg) * (2*PW)'(dlow_reg);
        else if (cmd.mul_avg)
            prod_reg <= (2*PW)'(avg_reg) * (2*PW)'(avg_reg);

        if (cmd.res_zero)
            avg_reg <= '0;
        else if (cmd.save_avg)
            avg_reg <= dlow_reg;

        if (cmd.save_msq)
            msq_reg <= dlow_reg;

        if (cmd.sqrt_load)
        begin
            sop_reg  <= (2*PW)'({diff, {FRAC_BITS{1'b0}}});
            srem_reg <= '0;
            sres_reg <= '0;
        end
        else if (cmd.res_zero)
            sres_reg <= '0;
        else if (cmd.sqrt_step)
        begin
            srem_reg <= (PW+2)'(sge ? (sfull - strial) : sfull);
            sres_reg <= {sres_reg[PW-2:0], sge};
            sop_reg  <= sop_reg << 2;
        end

        if (cmd.emit)
        begin
            out_avg_reg <= 17'(avg_reg);
            out_sd_reg  <= 17'(sres_reg);
            out_wc_reg  <= 13'(wc_reg);
        end
    end

    assign out_valid      = out_valid_reg;
    assign avg_identity   = out_avg_reg;
    assign identity_stdev = out_sd_reg;
    assign window_count   = out_wc_reg;

endmodule

// ===== rtl/core/sliding_window_identity_stats_top.sv =====
`timescale 1ns / 1ps

// Sliding-window percent identity of two aligned sequences.
// Input channel (in_valid/in_ready): one alignment column per transfer,
// residue_a and residue_b (46 is a gap) and last for the final column.
// Output channel (out_valid/out_ready): one result transfer per last column,
// mean identity and standard deviation in Q1.16 plus the window count.
// Config channel (cfg_valid/cfg_ready): window_size, taken only while idle;
// a write clears all running state so a new alignment starts.
// The block takes no new column until the current one is through. A
// column goes from input through update and window check, or straight to
// finish with a zero window; when it closes a counted window it then runs
// the radix-2 divider, one quotient bit per cycle (skipped with no common
// column), a square and the accumulate step.
// A last column adds the two final divides and the bitwise square root
// before the result is loaded into the output register. The next column is
// accepted while that result waits; only a new result stalls behind a
// receiver that holds out_ready low.
// Reset: window_size returns to 20 and all running state is cleared.
// The class ring memory needs no clearing: only written slots are read.
module sliding_window_identity_stats_top
    import swis_pkg::*;
#(
    parameter int MAX_LENGTH = 4096,
    parameter int FRAC_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [12:0] window_size,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  residue_a,
    input  logic [7:0]  residue_b,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [16:0] avg_identity,
    output logic [16:0] identity_stdev,
    output logic [12:0] window_count
);

    localparam int AW = $clog2(MAX_LENGTH);

    cmd_t          cmd;
    status_t       st;
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [1:0]    ram_wdata, ram_rdata;

    // Sequencer: steps each column through update, divide and accumulate.
    swis_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .st        (st),
        .cmd       (cmd)
    );

    // Counters, divider, multiplier, square root and output register.
    swis_dp #(
        .MAX_LENGTH (MAX_LENGTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (st),
        .window_size    (window_size),
        .residue_a      (residue_a),
        .residue_b      (residue_b),
        .last           (last),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .ram_re         (ram_re),
        .ram_raddr      (ram_raddr),
        .ram_rdata      (ram_rdata),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .avg_identity   (avg_identity),
        .identity_stdev (identity_stdev),
        .window_count   (window_count)
    );

    // Ring of column classes for the current window.
    swis_ram #(
        .WIDTH (2),
        .DEPTH (MAX_LENGTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // One column at a time: no transfer in the cycle after one is taken.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while a column is in flight");

    // No counted window means both statistics are zero.
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && window_count == 13'd0) |-> (avg_identity == 17'd0 &&
        identity_stdev == 17'd0))
        else $error("nonzero statistics with no window");

    // Mean identity never exceeds 1.0.
    a_avg_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(avg_identity) <= (32'd1 << FRAC_BITS)))
        else $error("mean identity out of range");

    // Window count is bounded by the window cap.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(window_count) <= MAX_LENGTH))
        else $error("window count out of range");

endmodule
